// ===== sv/wpr_pkg.sv =====
// wpr_pkg: shared types and field layout for the waypoint history ring
// used by waypoint_history_ring and its port checker; no dependencies
`default_nettype none

package wpr_pkg;

  localparam int WORD_W     = 32;
  localparam int POSE_W     = 4 * WORD_W;
  localparam int OFFSET_W   = 6;
  localparam int COUNT_W    = 7;

  localparam int IN_DATA_W  = POSE_W;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 144;
  localparam int OUT_USER_W = 3;

  // bit positions inside the output beat
  localparam int OUT_OFFSET_LSB = POSE_W;
  localparam int OUT_COUNT_LSB  = POSE_W + OFFSET_W;
  localparam int OUT_PAD_W      = OUT_DATA_W - POSE_W - OFFSET_W - COUNT_W;
  localparam int OUT_MOTION_BIT = 2;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_BACK  = 2'd1,
    CMD_FWD   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SHOWN  = 2'd0,
    ST_NOPOSE = 2'd1,
    ST_EMPTY  = 2'd2
  } status_t;

  // where the shown words of a result come from
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_POSE = 2'd1,
    SRC_RAM  = 2'd2
  } src_t;

endpackage

`default_nettype wire

// ===== sv/waypoint_history_ring.sv =====
// waypoint_history_ring: circular pose history with a browsing cursor
// depends on wpr_pkg and wpr_ram
//
//  channel | ports  | tdata (low bit up)                              | tuser (low bit up)
//  in      | in_*   | pose_x, pose_y, pose_bearing, time_ms           | cmd[1:0], pose_valid
//  out     | out_*  | shown_x, shown_y, shown_bearing, shown_time_ms, | status[1:0],
//          |        | cursor_offset, entry_count, 3 zero bits         | to_motion_topic
//
// one command per cycle; its result is valid the cycle after the input beat
// the latency is set by the registered read port of the history RAM
// a command code of 3 is taken and yields no result beat
// a stalled result holds the input off; reset clears pointers and count,
// the history RAM needs no clearing since a never-written entry is never read
`default_nettype none

module waypoint_history_ring
  import wpr_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // pose_x, pose_y, pose_bearing, time_ms
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // cmd[1:0], pose_valid
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // shown x, y, bearing, time, offset, count
  output logic [OUT_USER_W-1:0]      out_tuser   // status[1:0], to_motion_topic
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  logic [PTR_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  cursor_r, cursor_nxt;
  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic              motion_r, motion_nxt;
  src_t              src_r, src_nxt;
  logic [POSE_W-1:0] pose_r;

  logic              in_fire;
  logic [1:0]        in_cmd;
  logic              in_pose_valid;
  logic              has_result;
  logic              ram_we;
  logic              ram_re;
  logic [SUM_W-1:0]  rd_sum;
  logic [PTR_W-1:0]  rd_addr;
  logic [POSE_W-1:0] ram_rdata;
  logic [POSE_W-1:0] shown;

  assign in_fire       = in_tvalid && in_tready;
  assign in_cmd        = in_tuser[1:0];
  assign in_pose_valid = in_tuser[2];
  assign in_tready     = !out_valid_r || out_tready;

  always_comb begin
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    has_result = 1'b1;
    status_nxt = ST_SHOWN;
    motion_nxt = 1'b0;
    src_nxt    = SRC_ZERO;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (in_cmd)
      CMD_STORE: begin
        if (in_pose_valid) begin
          ram_we     = in_fire;
          slot_nxt   = (slot_r == PTR_W'(DEPTH - 1)) ? '0 : slot_r + PTR_W'(1);
          count_nxt  = (count_r == CNT_W'(DEPTH)) ? count_r : count_r + CNT_W'(1);
          cursor_nxt = '0;
          src_nxt    = SRC_POSE;
        end else begin
          status_nxt = ST_NOPOSE;
        end
      end
      CMD_BACK, CMD_FWD: begin
        motion_nxt = 1'b1;
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          src_nxt = SRC_RAM;
          ram_re  = in_fire;
          if (in_cmd == CMD_BACK) begin
            // stop at the oldest held entry
            if (CNT_W'(cursor_r) + CNT_W'(1) < count_r) begin
              cursor_nxt = cursor_r + PTR_W'(1);
            end
          end else if (cursor_r != '0) begin
            cursor_nxt = cursor_r - PTR_W'(1);
          end
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // slot of the entry at the cursor: write slot - 1 - cursor, modulo DEPTH
  always_comb begin
    rd_sum  = SUM_W'(slot_r) + SUM_W'(DEPTH - 1) - SUM_W'(cursor_nxt);
    rd_addr = (rd_sum >= SUM_W'(DEPTH)) ? PTR_W'(rd_sum - SUM_W'(DEPTH)) : PTR_W'(rd_sum);
  end

  wpr_ram #(
    .WIDTH (POSE_W),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      slot_r      <= slot_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= has_result;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      motion_r <= motion_nxt;
      src_r    <= src_nxt;
      if (ram_we) begin
        pose_r <= in_tdata;
      end
    end
  end

  always_comb begin
    case (src_r)
      SRC_POSE: shown = pose_r;
      SRC_RAM:  shown = ram_rdata;
      default:  shown = '0;
    endcase
  end

  // pointer state only moves on a new beat, so it still matches the pending result
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, COUNT_W'(count_r), OFFSET_W'(cursor_r), shown};
  assign out_tuser  = {motion_r, status_r};

endmodule

`default_nettype wire

// ===== sv/wpr_ram.sv =====
// wpr_ram: generic simple dual-port RAM, one write and one registered read port
// no package dependencies
`default_nettype none

module wpr_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/wpr_checker.sv =====
// wpr_checker: port-level assertions for waypoint_history_ring, bound to the top level
// depends on wpr_pkg
`default_nettype none

module wpr_checker
  import wpr_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,  // shown x, y, bearing, time, offset, count
  input wire logic [OUT_USER_W-1:0] out_tuser   // status[1:0], to_motion_topic
);

  logic [1:0]          out_status;
  logic                out_motion;
  logic [OFFSET_W-1:0] out_offset;
  logic [COUNT_W-1:0]  out_count;

  assign out_status = out_tuser[1:0];
  assign out_motion = out_tuser[OUT_MOTION_BIT];
  assign out_offset = out_tdata[OUT_OFFSET_LSB +: OFFSET_W];
  assign out_count  = out_tdata[OUT_COUNT_LSB +: COUNT_W];

  // a stalled result beat keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // with no result pending the input side is always open
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with no result pending");

  // empty history answers only browsing, with no entries and zero words
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status == ST_EMPTY) |->
      out_motion && (out_count == '0) && (out_tdata[POSE_W-1:0] == '0))
    else $error("bad empty-history result");

  // an ignored store shows nothing and goes to the store topic
  a_nopose: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status == ST_NOPOSE) |->
      !out_motion && (out_tdata[POSE_W-1:0] == '0))
    else $error("bad ignored-store result");

  // a store always leaves the cursor on the newest entry
  a_store_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status == ST_SHOWN) && !out_motion |-> out_offset == '0)
    else $error("store result with cursor off the newest entry");

endmodule

bind waypoint_history_ring wpr_checker u_wpr_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for waypoint_history_ring, a pose history ring
// with a browsing cursor; streams commands in and checks every result beat
// against its own model of the ring; depends on wpr_pkg and the ring rtl
`timescale 1ns / 100ps

module tb_top;
  import wpr_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 700;
  localparam logic [1:0] CMD_NONE = 2'd3;   // taken by the block, no result

  typedef struct packed {
    logic                drain_first;  // wait for all results before this beat
    logic [1:0]          cmd;
    logic                pose_valid;
    logic [POSE_W-1:0]   pose;         // time, bearing, y, x from high to low
  } nav_cmd_t;

  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   x;
    logic [WORD_W-1:0]   y;
    logic [WORD_W-1:0]   bearing;
    logic [WORD_W-1:0]   tm;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
    logic                motion;
  } snapshot_view_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // pose_x, pose_y, pose_bearing, time_ms
  logic [IN_USER_W-1:0] in_tuser = '0;   // cmd[1:0], pose_valid
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // shown x, y, bearing, time, offset, count
  logic [OUT_USER_W-1:0] out_tuser;      // status[1:0], to_motion_topic

  waypoint_history_ring #(.DEPTH(RING_DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ring model state
  logic [POSE_W-1:0] hist_words [RING_DEPTH];
  int wr_slot = 0;
  int held = 0;
  int cur_back = 0;

  nav_cmd_t pending_cmds[$];
  snapshot_view_t views_due[$];
  nav_cmd_t sent_cmd = '0;

  bit in_took = 1'b0;
  int fails = 0;
  int shown_beats = 0;
  int stalled = 0;
  int send_gap = 0, send_calm = 0;
  int take_hold = 0, take_calm = 0;
  bit long_hold_done = 1'b0;

  // mostly short gaps, a few long, and now and then a calm run with none
  function automatic int idle_span(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 90);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic history_step(input nav_cmd_t c);
    snapshot_view_t v;
    bit show;
    int slot;
    v = '0;
    show = 1'b0;
    if (c.cmd == CMD_NONE) return;
    if (c.cmd == CMD_STORE) begin
      if (!c.pose_valid) begin
        v.status = ST_NOPOSE;
      end else begin
        hist_words[wr_slot] = c.pose;
        wr_slot = (wr_slot + 1) % RING_DEPTH;
        if (held < RING_DEPTH) held++;
        cur_back = 0;
        v.status = ST_SHOWN;
        show = 1'b1;
      end
    end else if (held == 0) begin
      v.status = ST_EMPTY;
      v.motion = 1'b1;
    end else begin
      if (c.cmd == CMD_BACK && cur_back + 1 < held) cur_back++;
      else if (c.cmd == CMD_FWD && cur_back > 0) cur_back--;
      v.status = ST_SHOWN;
      v.motion = 1'b1;
      show = 1'b1;
    end
    if (show) begin
      slot = (wr_slot + RING_DEPTH - 1 - cur_back) % RING_DEPTH;
      {v.tm, v.bearing, v.y, v.x} = hist_words[slot];
    end
    v.offset = cur_back[OFFSET_W-1:0];
    v.count = held[COUNT_W-1:0];
    views_due.push_back(v);
  endtask

  // sampling side: result check first, then the command taken at this edge
  always @(posedge clk) begin
    snapshot_view_t seen, want;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.status = status_t'(out_tuser[1:0]);
        {seen.tm, seen.bearing, seen.y, seen.x} = out_tdata[POSE_W-1:0];
        seen.offset = out_tdata[OUT_OFFSET_LSB +: OFFSET_W];
        seen.count = out_tdata[OUT_COUNT_LSB +: COUNT_W];
        seen.motion = out_tuser[OUT_MOTION_BIT];
        shown_beats++;
        if (views_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat: %p", seen);
        end else begin
          want = views_due.pop_front();
          if (seen.status !== want.status || seen.x !== want.x || seen.y !== want.y ||
              seen.bearing !== want.bearing || seen.tm !== want.tm ||
              seen.offset !== want.offset || seen.count !== want.count ||
              seen.motion !== want.motion) begin
            fails++;
            if (fails <= 10) begin
              $display("result %0d mismatch", shown_beats);
              $display("  exp: %p", want);
              $display("  got: %p", seen);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        history_step(sent_cmd);
        in_took = 1'b1;
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    nav_cmd_t nxt;
    logic nvalid;
    nxt = sent_cmd;
    nvalid = in_tvalid;
    if (rst_n && (!in_tvalid || in_took)) begin
      nvalid = 1'b0;
      if (in_took) send_gap = idle_span(send_calm);
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].drain_first && views_due.size() != 0)) begin
        nxt = pending_cmds.pop_front();
        nvalid = 1'b1;
      end
    end
    in_tvalid <= nvalid;
    in_tdata <= nxt.pose;
    in_tuser <= {nxt.pose_valid, nxt.cmd};
    sent_cmd <= nxt;
  end

  // result receiver, with one long hold-off to back the ring up into the input
  always @(negedge clk) begin
    logic nready;
    nready = 1'b0;
    if (rst_n) begin
      if (!long_hold_done && shown_beats >= 150) begin
        long_hold_done = 1'b1;
        take_hold = LONG_HOLD;
      end
      if (take_hold > 0) begin
        take_hold--;
      end else begin
        nready = 1'b1;
        take_hold = idle_span(take_calm);
      end
    end
    out_tready <= nready;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stalled = 0;
      else stalled++;
      if (stalled >= STALL_LIMIT) begin
        $display("waypoint_history_ring verification failed");
        $finish;
      end
    end
  end

  function automatic logic [POSE_W-1:0] rand_pose();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  int live_items = 0;

  task automatic queue_cmd(input logic [1:0] c, input logic v, input logic [POSE_W-1:0] w,
                           input logic drain);
    nav_cmd_t n;
    n.drain_first = drain;
    n.cmd = c;
    n.pose_valid = v;
    n.pose = w;
    pending_cmds.push_back(n);
    if (c != CMD_NONE) live_items++;
  endtask

  initial begin
    int kind, len, seq_no, target;
    logic lead;

    // directed: empty history, invalid pose, extremes, clamps at both ends
    queue_cmd(CMD_BACK, 1'b1, rand_pose(), 1'b0);
    queue_cmd(CMD_FWD, 1'b0, rand_pose(), 1'b0);
    queue_cmd(CMD_STORE, 1'b0, '1, 1'b0);
    queue_cmd(CMD_NONE, 1'b1, rand_pose(), 1'b0);
    queue_cmd(CMD_STORE, 1'b1, '1, 1'b0);
    queue_cmd(CMD_STORE, 1'b1, '0, 1'b0);
    queue_cmd(CMD_BACK, 1'b0, '0, 1'b0);
    queue_cmd(CMD_BACK, 1'b1, '1, 1'b0);          // already at the oldest
    queue_cmd(CMD_FWD, 1'b1, rand_pose(), 1'b0);
    queue_cmd(CMD_FWD, 1'b0, rand_pose(), 1'b0);  // already at the newest
    queue_cmd(CMD_STORE, 1'b0, rand_pose(), 1'b0);
    queue_cmd(CMD_NONE, 1'b0, '1, 1'b0);
    queue_cmd(CMD_STORE, 1'b1, {4{32'h5555_aaaa}}, 1'b0);
    queue_cmd(CMD_STORE, 1'b1, {4{32'haaaa_5555}}, 1'b0);
    queue_cmd(CMD_BACK, 1'b1, rand_pose(), 1'b0);
    queue_cmd(CMD_BACK, 1'b1, rand_pose(), 1'b0);
    queue_cmd(CMD_STORE, 1'b1, rand_pose(), 1'b0); // cursor snaps back to newest
    queue_cmd(CMD_BACK, 1'b0, rand_pose(), 1'b0);
    queue_cmd(CMD_FWD, 1'b1, rand_pose(), 1'b0);

    // random: store bursts that wrap the ring, long browse runs, some noise
    seq_no = 0;
    target = live_items + RANDOM_ITEMS;
    while (live_items < target) begin
      seq_no++;
      lead = (seq_no % 40 == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
        repeat (len) begin
          queue_cmd(CMD_STORE, $urandom_range(0, 15) != 0, rand_pose(), lead);
          lead = 1'b0;
        end
      end else if (kind <= 7) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
        repeat (len) begin
          queue_cmd(kind <= 5 ? CMD_BACK : CMD_FWD, 1'($urandom_range(0, 1)), rand_pose(),
                    lead);
          lead = 1'b0;
        end
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 10)) begin
          queue_cmd(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)), rand_pose(), lead);
          lead = 1'b0;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          queue_cmd($urandom_range(0, 1) ? CMD_NONE : CMD_STORE, $urandom_range(0, 3) == 0,
                    rand_pose(), lead);
          lead = 1'b0;
        end
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // checked at the rising edge so the driver's updates have settled
    while (pending_cmds.size() != 0 || in_tvalid || views_due.size() != 0)
      @(posedge clk);
    repeat (20) @(negedge clk);
    fails += views_due.size();
    if (fails == 0) begin
      $display("waypoint_history_ring verification clean");
    end else begin
      $display("waypoint_history_ring verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/wpr_pkg.sv
sv/wpr_ram.sv
sv/waypoint_history_ring.sv
sv/wpr_checker.sv
bench/tb_top.sv
